/* rtl/led_mode_blink_fade_pwm_defines.svh */
// ----------------------------------------------------------------------------
// led mode controller assertion macros
// shared concurrent assertion forms, synchronous active-high reset disable
// ----------------------------------------------------------------------------
`ifndef LED_MODE_BLINK_FADE_PWM_DEFINES_SVH
`define LED_MODE_BLINK_FADE_PWM_DEFINES_SVH

// same-cycle implication
`define LMBF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lmbf assertion failed");

// next-cycle implication
`define LMBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lmbf assertion failed");

`endif

/* rtl/lmbf_pkg.sv */
// ----------------------------------------------------------------------------
// lmbf_pkg
// types, command codes, register indexes and reset values of the led controller
// ----------------------------------------------------------------------------
package lmbf_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int PERIOD_WIDTH = 16;
   localparam int DUTY_WIDTH   = 10;
   localparam int BYTE_WIDTH   = 8;
   localparam int MODE_WIDTH   = 2;
   localparam int CSR_WIDTH    = 16;
   localparam int CSR_IDX_WIDTH = 2;

   typedef logic [DUTY_WIDTH-1:0]   duty_type;
   typedef logic [PERIOD_WIDTH-1:0] period_type;
   typedef logic [BYTE_WIDTH-1:0]   byte_type;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_DARK  = 2'd0,
      MODE_ON    = 2'd1,
      MODE_FLASH = 2'd2,
      MODE_FADE  = 2'd3
   } mode_type;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_CMD  = 1'b1;

   localparam byte_type CMD_ON    = 8'h6f;
   localparam byte_type CMD_OFF   = 8'h78;
   localparam byte_type CMD_BLINK = 8'h62;
   localparam byte_type CMD_FADE  = 8'h66;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_BLINK_HALF_PERIOD = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_FADE_INTERVAL     = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_FADE_INCREMENT    = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_DUTY_MAX          = 2'd3;

   localparam period_type BLINK_HALF_PERIOD_RESET = 16'd500;
   localparam period_type FADE_INTERVAL_RESET     = 16'd20;
   localparam duty_type   FADE_INCREMENT_RESET    = 10'd20;
   localparam duty_type   DUTY_MAX_RESET          = 10'd999;

   typedef struct packed {
      duty_type duty;
      logic     down;
   } fade_state_type;

endpackage

/* rtl/lmbf_if.sv */
// ----------------------------------------------------------------------------
// lmbf_if
// valid/ready channels of the led controller: request and response words
// ----------------------------------------------------------------------------
interface lmbf_req_if;
   logic                 valid;
   logic                 ready;
   logic                 func;
   lmbf_pkg::byte_type   rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface lmbf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   lmbf_pkg::duty_type                   pwm_compare;
   logic [lmbf_pkg::MODE_WIDTH-1:0]      led_state;
   logic                                 unknown_cmd;

   modport source (output valid, output pwm_compare, output led_state,
                   output unknown_cmd, input ready);
   modport sink   (input valid, input pwm_compare, input led_state,
                   input unknown_cmd, output ready);
endinterface

/* rtl/lmbf_fade_step.sv */
// ----------------------------------------------------------------------------
// lmbf_fade_update
// one fade update: step duty up or down, clamp at the ends, turn direction
// ----------------------------------------------------------------------------
module lmbf_fade_update (
   input  lmbf_pkg::fade_state_type cur,
   input  lmbf_pkg::duty_type       duty_max,
   input  lmbf_pkg::duty_type       increment,
   output lmbf_pkg::fade_state_type nxt
);

   logic [lmbf_pkg::DUTY_WIDTH:0] sum;
   lmbf_pkg::duty_type            diff;

   assign sum  = {1'b0, cur.duty} + {1'b0, increment};
   assign diff = cur.duty - increment;

   always_comb begin
      nxt = cur;
      if (!cur.down) begin
         if (sum >= {1'b0, duty_max}) begin
            nxt.duty = duty_max;
            nxt.down = 1'b1;
         end else begin
            nxt.duty = sum[lmbf_pkg::DUTY_WIDTH-1:0];
         end
      end else begin
         if (increment >= cur.duty) begin
            nxt.duty = '0;
            nxt.down = 1'b0;
         end else if (diff > duty_max) begin
            nxt.duty = duty_max;
         end else begin
            nxt.duty = diff;
         end
      end
   end

endmodule

/* rtl/led_mode_blink_fade_pwm.sv */
// ----------------------------------------------------------------------------
// led_mode_blink_fade_pwm
// led mode controller: off, on, blink and fade, giving the pwm compare value
//
//   channel  dir  handshake     word
//   req      in   valid/ready   func, rx_byte
//   rsp      out  valid/ready   pwm_compare, led_state, unknown_cmd
//   csr      in   write enable  index, 16-bit data
//
// one request word per cycle; its response is registered and shows in the
// cycle after acceptance. the single response register sets the rate.
// req.ready is high while the response register is empty or being taken.
// a stalled response holds its word and blocks new requests.
// reset is synchronous: all but the response data registers take reset values.
// ----------------------------------------------------------------------------
`include "led_mode_blink_fade_pwm_defines.svh"

module led_mode_blink_fade_pwm #(
   parameter int COUNT_WIDTH = lmbf_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lmbf_req_if.sink                             req_chan,
   lmbf_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [lmbf_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [lmbf_pkg::CSR_WIDTH-1:0]       csr_wdata
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > lmbf_pkg::PERIOD_WIDTH) ?
                              COUNT_WIDTH : lmbf_pkg::PERIOD_WIDTH;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [CMP_WIDTH-1:0]   cmp_type;

   lmbf_pkg::period_type blink_half_period_ff;
   lmbf_pkg::period_type fade_interval_ff;
   lmbf_pkg::duty_type   fade_increment_ff;
   lmbf_pkg::duty_type   duty_max_ff;

   lmbf_pkg::mode_type       mode_ff, mode_in;
   count_type                blink_elapsed_ff, blink_elapsed_in;
   logic                     blink_level_ff, blink_level_in;
   count_type                fade_elapsed_ff, fade_elapsed_in;
   lmbf_pkg::fade_state_type fade_ff, fade_in, fade_next;
   lmbf_pkg::duty_type       compare_ff, compare_in;
   logic                     unknown_in;

   logic                             rsp_valid_ff;
   lmbf_pkg::duty_type               rsp_compare_ff;
   logic [lmbf_pkg::MODE_WIDTH-1:0]  rsp_mode_ff;
   logic                             rsp_unknown_ff;

   logic      accept;
   count_type blink_count_up;
   count_type fade_count_up;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pwm_compare = rsp_compare_ff;
   assign rsp_chan.led_state   = rsp_mode_ff;
   assign rsp_chan.unknown_cmd = rsp_unknown_ff;

   // saturating millisecond counters
   assign blink_count_up = (blink_elapsed_ff == '1) ? blink_elapsed_ff :
                           blink_elapsed_ff + count_type'(1);
   assign fade_count_up  = (fade_elapsed_ff == '1) ? fade_elapsed_ff :
                           fade_elapsed_ff + count_type'(1);

   lmbf_fade_update u_fade_update (
      .cur       (fade_ff),
      .duty_max  (duty_max_ff),
      .increment (fade_increment_ff),
      .nxt       (fade_next)
   );

   always_comb begin
      mode_in          = mode_ff;
      blink_elapsed_in = blink_elapsed_ff;
      blink_level_in   = blink_level_ff;
      fade_elapsed_in  = fade_elapsed_ff;
      fade_in          = fade_ff;
      compare_in       = compare_ff;
      unknown_in       = 1'b0;
      if (req_chan.func == lmbf_pkg::FUNC_CMD) begin
         case (req_chan.rx_byte)
            lmbf_pkg::CMD_ON: begin
               mode_in = lmbf_pkg::MODE_ON;
            end
            lmbf_pkg::CMD_OFF: begin
               mode_in = lmbf_pkg::MODE_DARK;
            end
            lmbf_pkg::CMD_BLINK: begin
               mode_in          = lmbf_pkg::MODE_FLASH;
               blink_elapsed_in = '0;
               blink_level_in   = 1'b0;
            end
            lmbf_pkg::CMD_FADE: begin
               mode_in         = lmbf_pkg::MODE_FADE;
               fade_elapsed_in = '0;
               fade_in         = '0;
            end
            default: begin
               unknown_in = 1'b1;
            end
         endcase
      end else begin
         case (mode_ff)
            lmbf_pkg::MODE_FLASH: begin
               blink_elapsed_in = blink_count_up;
               if (cmp_type'(blink_count_up) >= cmp_type'(blink_half_period_ff)) begin
                  blink_level_in   = !blink_level_ff;
                  compare_in       = blink_level_ff ? '0 : duty_max_ff;
                  blink_elapsed_in = '0;
               end
            end
            lmbf_pkg::MODE_FADE: begin
               fade_elapsed_in = fade_count_up;
               if (cmp_type'(fade_count_up) >= cmp_type'(fade_interval_ff)) begin
                  fade_in         = fade_next;
                  compare_in      = fade_next.duty;
                  fade_elapsed_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
      if (mode_in == lmbf_pkg::MODE_ON) begin
         compare_in = duty_max_ff;
      end else if (mode_in == lmbf_pkg::MODE_DARK) begin
         compare_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_half_period_ff <= lmbf_pkg::BLINK_HALF_PERIOD_RESET;
         fade_interval_ff     <= lmbf_pkg::FADE_INTERVAL_RESET;
         fade_increment_ff    <= lmbf_pkg::FADE_INCREMENT_RESET;
         duty_max_ff          <= lmbf_pkg::DUTY_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lmbf_pkg::REG_BLINK_HALF_PERIOD: begin
               blink_half_period_ff <= csr_wdata;
            end
            lmbf_pkg::REG_FADE_INTERVAL: begin
               fade_interval_ff <= csr_wdata;
            end
            lmbf_pkg::REG_FADE_INCREMENT: begin
               fade_increment_ff <= csr_wdata[lmbf_pkg::DUTY_WIDTH-1:0];
            end
            lmbf_pkg::REG_DUTY_MAX: begin
               duty_max_ff <= csr_wdata[lmbf_pkg::DUTY_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= lmbf_pkg::MODE_DARK;
         blink_elapsed_ff <= '0;
         blink_level_ff   <= 1'b0;
         fade_elapsed_ff  <= '0;
         fade_ff          <= '0;
         compare_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff          <= mode_in;
            blink_elapsed_ff <= blink_elapsed_in;
            blink_level_ff   <= blink_level_in;
            fade_elapsed_ff  <= fade_elapsed_in;
            fade_ff          <= fade_in;
            compare_ff       <= compare_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_compare_ff <= compare_in;
         rsp_mode_ff    <= mode_in;
         rsp_unknown_ff <= unknown_in;
      end
   end

   `LMBF_ASSERT_SAME(a_off_is_dark, clock, reset,
      rsp_valid_ff && (rsp_mode_ff == lmbf_pkg::MODE_DARK), rsp_compare_ff == '0)
   `LMBF_ASSERT_NEXT(a_tick_keeps_on, clock, reset,
      accept && (req_chan.func == lmbf_pkg::FUNC_TICK) && (mode_ff == lmbf_pkg::MODE_ON),
      rsp_valid_ff && (rsp_mode_ff == lmbf_pkg::MODE_ON) && !rsp_unknown_ff)
   `LMBF_ASSERT_NEXT(a_unknown_keeps_mode, clock, reset,
      accept && unknown_in,
      rsp_valid_ff && rsp_unknown_ff && (rsp_mode_ff == $past(mode_ff)))
   `LMBF_ASSERT_NEXT(a_fade_cmd_restarts, clock, reset,
      accept && (req_chan.func == lmbf_pkg::FUNC_CMD) &&
      (req_chan.rx_byte == lmbf_pkg::CMD_FADE),
      (fade_ff.duty == '0) && !fade_ff.down && (fade_elapsed_ff == '0))

endmodule
